// ===== design/sbph_pkg.sv =====
// Shared constants and types for the seeded bit-permutation hash unit.
// No dependencies; the interfaces and the top level import this package.

package sbph_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int RES_W = 5;
    localparam int RES_COUNT = 1 << RES_W;

    // Bytes in one seed packet; any value from 21 to 31 is supported.
    localparam int PACKET_BYTES = 31;
    localparam logic [RES_W-1:0] LAST_POS = RES_W'(PACKET_BYTES - 1);

    // Residue store: two banks of one entry per packet position.
    localparam int RES_DEPTH = 2 * RES_COUNT;

    localparam logic [WORD_W-1:0] SELECT_MASK = 32'h0011_707E;
    localparam logic [WORD_W-1:0] WORK_START = 32'h0012_3456;
    localparam logic [WORD_W-1:0] PRODUCT_START = 32'h8175_0E16;

    localparam logic [BYTE_W-1:0] INIT_TABLE [RES_COUNT] = '{
        8'h11, 8'h9F, 8'h30, 8'h01, 8'h82, 8'hE7, 8'hE3, 8'h89,
        8'h38, 8'hF4, 8'h55, 8'hA4, 8'hE5, 8'h6D, 8'hE8, 8'h37,
        8'h7A, 8'hCB, 8'h79, 8'hBE, 8'h7B, 8'h56, 8'h8A, 8'hCC,
        8'hFC, 8'h52, 8'h9D, 8'hE6, 8'h4E, 8'h73, 8'hEF, 8'h00
    };

    typedef logic [RES_W-1:0] residue_t;
    typedef logic [WORD_W-1:0] word_t;

    // Control carried from the residue stage to the permutation stage.
    typedef struct packed {
        logic     valid;
        logic     first;
        logic     last;
        logic     sel;
        logic     from_table;
        residue_t pos;
        residue_t res;
    } perm_ctrl_t;

endpackage

// ===== design/sbph_byte_if.sv =====
// Channel interface carrying one seed byte per transfer.
// Depends on sbph_pkg.

interface sbph_byte_if
    import sbph_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

// ===== design/sbph_word_if.sv =====
// Channel interface carrying one 32-bit product word per transfer.
// Depends on sbph_pkg.

interface sbph_word_if
    import sbph_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] product_word;

    modport source (output valid, output product_word, input ready);
    modport sink (input valid, input product_word, output ready);
endinterface

// ===== design/sbph_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.

module sbph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/seeded_bit_permutation_hash_unit.sv =====
// Top level of the seeded bit-permutation hash unit.
// Accepts one seed byte per cycle while not stalled and returns one product word per packet.
// The last byte of a packet passes the permutation stage register, then the output register.
// Throughput: one byte per cycle while not stalled; the free-residue search is a single
// cyclic priority encode on the used mask and the residue store is a two-bank RAM with one
// read port. Reset: control clears at once; the first packet takes its old residues from a
// constant table, so the residue RAM needs no clearing pass.

module seeded_bit_permutation_hash_unit
    import sbph_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    sbph_byte_if.sink          seed,
    sbph_word_if.source        result
);

    // Residue stage state.
    residue_t            pos_reg;
    residue_t            pos_next;
    logic [WORD_W-1:0]   used_mask_reg;
    logic [WORD_W-1:0]   used_mask_next;
    logic                bank_reg;
    logic                bank_next;
    logic                table_mode_reg;
    logic                table_mode_next;

    // Permutation stage state.
    perm_ctrl_t          s1_reg;
    perm_ctrl_t          s1_next;
    word_t               work_reg;
    word_t               work_next;
    word_t               product_reg;
    word_t               product_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    word_t               out_data_reg;
    word_t               out_data_next;

    logic                accept;
    logic                stall;
    logic                s1_fire;
    logic                is_first;
    logic                is_last;
    residue_t            start_res;
    residue_t            res;
    logic [WORD_W-1:0]   avail;
    logic [2*WORD_W-1:0] avail_dbl;
    logic [WORD_W-1:0]   rot;
    residue_t            offset;
    logic                found;
    residue_t            old_res;
    residue_t            ram_rdata;
    logic [$clog2(RES_DEPTH)-1:0] ram_waddr;
    logic [$clog2(RES_DEPTH)-1:0] ram_raddr;

    // The permutation stage holds only when it has a product and the output is still full.
    assign stall = s1_reg.valid && s1_reg.last && out_valid_reg && !result.ready;
    assign s1_fire = s1_reg.valid && !stall;
    assign seed.ready = !stall;
    assign accept = seed.valid && seed.ready;

    assign is_first = (pos_reg == '0);
    assign is_last = (pos_reg == LAST_POS);
    assign start_res = seed.source_byte[RES_W-1:0];

    // First free nonzero residue, cyclic from the start value; a first byte keeps the start.
    always_comb
    begin
        avail = ~used_mask_reg & ~WORD_W'(1);
        avail_dbl = {avail, avail} >> start_res;
        rot = avail_dbl[WORD_W-1:0];
        found = 1'b0;
        offset = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (rot[i])
            begin
                found = 1'b1;
                offset = RES_W'(i);
            end
        end
        if (is_first || !found)
        begin
            res = start_res;
        end
        else
        begin
            res = start_res + offset;
        end
    end

    // The bank in use holds the previous packet's residues; the other one takes this packet's.
    assign ram_waddr = {~bank_reg, pos_reg};
    assign ram_raddr = {bank_reg, pos_reg};

    sbph_ram #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_residue_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (ram_waddr),
        .wdata (res),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pos_next = pos_reg;
        used_mask_next = used_mask_reg;
        bank_next = bank_reg;
        table_mode_next = table_mode_reg;
        if (accept)
        begin
            used_mask_next = (is_first ? '0 : used_mask_reg) | (WORD_W'(1) << res);
            if (is_last)
            begin
                pos_next = '0;
                bank_next = ~bank_reg;
                table_mode_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + RES_W'(1);
            end
        end
    end

    always_comb
    begin
        s1_next = s1_reg;
        if (accept)
        begin
            s1_next.valid = 1'b1;
            s1_next.first = is_first;
            s1_next.last = is_last;
            s1_next.sel = SELECT_MASK[pos_reg];
            s1_next.from_table = table_mode_reg;
            s1_next.pos = pos_reg;
            s1_next.res = res;
        end
        else if (!stall)
        begin
            s1_next.valid = 1'b0;
        end
    end

    // Where selected, copy one bit of the previous product into the new residue's position.
    always_comb
    begin
        old_res = s1_reg.from_table ? INIT_TABLE[s1_reg.pos][RES_W-1:0] : ram_rdata;
        work_next = work_reg;
        product_next = product_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next = out_data_reg;
        if (s1_fire)
        begin
            work_next = s1_reg.first ? WORK_START : work_reg;
            if (s1_reg.sel)
            begin
                work_next[s1_reg.res] = product_reg[old_res];
            end
            if (s1_reg.last)
            begin
                product_next = work_next;
                out_valid_next = 1'b1;
                out_data_next = work_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            used_mask_reg <= '0;
            bank_reg <= 1'b0;
            table_mode_reg <= 1'b1;
            s1_reg <= '0;
            work_reg <= WORK_START;
            product_reg <= PRODUCT_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            used_mask_reg <= used_mask_next;
            bank_reg <= bank_next;
            table_mode_reg <= table_mode_next;
            s1_reg <= s1_next;
            work_reg <= work_next;
            product_reg <= product_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.product_word = out_data_reg;

    // A packet's last byte leaving the permutation stage always fills the output register.
    a_last_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.valid && s1_reg.last && !stall) |=> out_valid_reg)
        else $error("product of a finished packet was not presented");

    // The first byte of a packet leaves exactly one residue marked as used.
    a_first_byte_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_first) |=> $onehot(used_mask_reg))
        else $error("used mask not restarted on the first byte");

    // Every byte after the first gets a nonzero residue.
    a_later_residue_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.valid && !s1_reg.first) |-> (s1_reg.res != '0))
        else $error("zero residue given to a later byte");

    // No new byte is taken while the permutation stage is held.
    a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> $stable(s1_reg))
        else $error("permutation stage changed while held");

endmodule
